// File: rtl/core/arfs_pkg.sv
// ----------------------------------------------------------------------------
// ADIF record field scanner package
// Shared constants, result kinds, scan phases and helper functions.
// ----------------------------------------------------------------------------
package arfs_pkg;

    // Longest trimmed tag name that is kept.
    localparam int NAME_MAX          = 32;
    // Bytes of one message that are scanned before it fails.
    localparam int MESSAGE_MAX_BYTES = 65536;

    localparam int NAME_AW = $clog2(NAME_MAX);
    localparam int NAME_CW = $clog2(NAME_MAX + 1);
    localparam int POS_W   = $clog2(MESSAGE_MAX_BYTES + 1);
    localparam int LEN_W   = 17;

    localparam logic [LEN_W-1:0] LEN_SAT = 17'h10000;

    // Scan phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TEXT  = 3'd1;
    localparam logic [2:0] PH_NAME  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_TYPE  = 3'd4;
    localparam logic [2:0] PH_VALUE = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // Length parser states.
    localparam logic [2:0] LP_WS    = 3'd0;
    localparam logic [2:0] LP_PLUS  = 3'd1;
    localparam logic [2:0] LP_MINUS = 3'd2;
    localparam logic [2:0] LP_DIG   = 3'd3;
    localparam logic [2:0] LP_NDIG  = 3'd4;
    localparam logic [2:0] LP_TWS   = 3'd5;
    localparam logic [2:0] LP_NTWS  = 3'd6;
    localparam logic [2:0] LP_BAD   = 3'd7;

    // Result kinds.
    localparam logic [2:0] K_CHAR    = 3'd0;
    localparam logic [2:0] K_HEADER  = 3'd1;
    localparam logic [2:0] K_VALUE   = 3'd2;
    localparam logic [2:0] K_ACCEPT  = 3'd3;
    localparam logic [2:0] K_DISCARD = 3'd4;
    localparam logic [2:0] K_FAIL    = 3'd5;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_H     = 8'h48;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

// File: rtl/core/arfs_name_mem.sv
// ----------------------------------------------------------------------------
// Tag name store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arfs_name_mem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [arfs_pkg::NAME_AW-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic [arfs_pkg::NAME_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import arfs_pkg::*;

    logic [7:0] mem [NAME_MAX];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/arfs_len_step.sv
// ----------------------------------------------------------------------------
// Length digit unit
// Advances the declared-length parser by one byte: sign, digits, whitespace.
// ----------------------------------------------------------------------------
module arfs_len_step (
    input  logic [7:0]                 in_byte,
    input  logic [2:0]                 lp_cur,
    input  logic [arfs_pkg::LEN_W-1:0] acc_cur,
    output logic [2:0]                 lp_new,
    output logic [arfs_pkg::LEN_W-1:0] acc_new
);
    import arfs_pkg::*;

    logic [LEN_W-1:0] base;
    logic [20:0]      v;

    always_comb
    begin
        base    = (lp_cur <= LP_MINUS) ? '0 : acc_cur;
        v       = ({4'b0, base} << 3) + ({4'b0, base} << 1) + 21'(in_byte[3:0]);
        lp_new  = lp_cur;
        acc_new = acc_cur;
        if (is_digit(in_byte) && lp_cur <= LP_NDIG)
        begin
            acc_new = (v > 21'(LEN_SAT)) ? LEN_SAT : v[LEN_W-1:0];
            lp_new  = (lp_cur == LP_MINUS || lp_cur == LP_NDIG) ? LP_NDIG : LP_DIG;
        end
        else if (is_ws(in_byte) && (lp_cur == LP_WS || lp_cur >= LP_DIG))
        begin
            if (lp_cur == LP_DIG)
            begin
                lp_new = LP_TWS;
            end
            else if (lp_cur == LP_NDIG)
            begin
                lp_new = LP_NTWS;
            end
        end
        else if (lp_cur == LP_WS && in_byte == CH_PLUS)
        begin
            lp_new = LP_PLUS;
        end
        else if (lp_cur == LP_WS && in_byte == CH_MINUS)
        begin
            lp_new = LP_MINUS;
        end
        else
        begin
            lp_new = LP_BAD;
        end
    end

endmodule

// File: rtl/core/adif_record_field_scanner.sv
// ----------------------------------------------------------------------------
// ADIF record field scanner
// Scans messages for ADIF tags and streams names, headers, values and outcomes.
// ----------------------------------------------------------------------------
// The byte channel takes one message byte per beat, with first_byte marking
// the start of a message (which restarts the scanner) and final_byte its end.
// The result channel gives one result per beat; run_end marks the last
// result caused by an input byte. Both channels move a beat when valid is
// high and stall is low.
// A byte that gives no result leaves byte_stall low, so the next byte is not
// held back. A byte that gives results is taken in first and its results then
// go out one by one through the output register, so a value byte gives one
// result and a tag close gives the trimmed name characters and the header.
// A final byte that fails the record adds a fail beat as its last result.
// The rate is set by the single output register, which a small sequencer
// feeds one result a cycle while the output register is free, reading the
// name store one entry a cycle during the name burst.
// While results of a byte are pending, byte_stall is held high.
// After reset the scanner waits for a byte with first_byte set; other bytes
// are ignored. When the receiver stalls, the result held in the output
// register stays put and the sequencer waits; a byte that gives no result
// may still be taken while the last result waits to be taken.
// ----------------------------------------------------------------------------
module adif_record_field_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        first_byte,
    input  logic        final_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  kind,
    output logic [7:0]  char_value,
    output logic [15:0] field_length,
    output logic [7:0]  field_number,
    output logic [15:0] span_start,
    output logic [15:0] span_end,
    output logic        run_end
);
    import arfs_pkg::*;

    // Sequencer states.
    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_NAME = 3'd1;
    localparam logic [2:0] SQ_HEAD = 3'd2;
    localparam logic [2:0] SQ_ONE  = 3'd3;
    localparam logic [2:0] SQ_FAIL = 3'd4;

    // Scanner state.
    logic [2:0]         phase_reg, phase_next;
    logic [NAME_CW-1:0] nc_reg, nc_next;
    logic [NAME_CW-1:0] nt_reg, nt_next;
    logic [LEN_W-1:0]   acc_reg, acc_next;
    logic [2:0]         lp_reg, lp_next;
    logic [15:0]        rem_reg, rem_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               bnone_reg, bnone_next;
    logic [15:0]        begin_reg, begin_next;
    logic [15:0]        topen_reg, topen_next;
    logic [7:0]         fields_reg, fields_next;
    logic [7:0]         sh0_reg, sh1_reg, sh2_reg;

    // Sequencer and pending results.
    logic [2:0]         seq_reg, seq_next;
    logic [NAME_CW-1:0] k_reg, k_next;
    logic               tail_reg, tail_next;
    logic [2:0]         pkind_reg, pkind_next;
    logic [7:0]         pchar_reg, pchar_next;
    logic [7:0]         pfnum_reg, pfnum_next;
    logic [15:0]        pss_reg, pss_next;
    logic [15:0]        pse_reg, pse_next;
    logic [15:0]        hlen_reg, hlen_next;

    // Output register.
    logic               ov_reg, ov_next;
    logic [2:0]         okind_reg, okind_next;
    logic [7:0]         ochar_reg, ochar_next;
    logic [15:0]        olen_reg, olen_next;
    logic [7:0]         ofnum_reg, ofnum_next;
    logic [15:0]        oss_reg, oss_next;
    logic [15:0]        ose_reg, ose_next;
    logic               orun_reg, orun_next;

    // Values seen by the current byte after any restart.
    logic [2:0]         c_ph;
    logic [NAME_CW-1:0] c_nc;
    logic [NAME_CW-1:0] c_nt;
    logic [LEN_W-1:0]   c_acc;
    logic [2:0]         c_lp;
    logic [15:0]        c_rem;
    logic [POS_W-1:0]   c_pos;
    logic               c_bnone;
    logic [15:0]        c_begin;
    logic [7:0]         c_fields;

    logic [2:0]         ls_lp;
    logic [LEN_W-1:0]   ls_acc;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic [7:0]         rd_data;
    logic               byte_acc;
    logic               out_free;

    assign byte_acc = byte_valid && !byte_stall;
    assign out_free = !ov_reg || !result_stall;
    assign byte_stall = (seq_reg != SQ_IDLE);

    assign c_ph     = first_byte ? PH_TEXT : phase_reg;
    assign c_nc     = first_byte ? '0 : nc_reg;
    assign c_nt     = first_byte ? '0 : nt_reg;
    assign c_acc    = first_byte ? '0 : acc_reg;
    assign c_lp     = first_byte ? LP_WS : lp_reg;
    assign c_rem    = first_byte ? '0 : rem_reg;
    assign c_pos    = first_byte ? '0 : pos_reg;
    assign c_bnone  = first_byte ? 1'b1 : bnone_reg;
    assign c_begin  = first_byte ? '0 : begin_reg;
    assign c_fields = first_byte ? '0 : fields_reg;

    arfs_len_step u_len (
        .in_byte (in_byte),
        .lp_cur  (c_lp),
        .acc_cur (c_acc),
        .lp_new  (ls_lp),
        .acc_new (ls_acc)
    );

    arfs_name_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (c_nc[NAME_AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (k_next[NAME_AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic       r_fail;
        logic       r_one;
        logic       r_burst;
        logic       r_tail;
        logic       do_close;
        logic       is_eor;
        logic       is_eoh;
        logic       bad_len;
        logic [7:0] idx;
        logic [7:0] up;

        r_fail   = 1'b0;
        r_one    = 1'b0;
        r_burst  = 1'b0;
        r_tail   = 1'b0;
        do_close = 1'b0;
        is_eor   = (nt_reg == NAME_CW'(3)) && sh0_reg == CH_E && sh1_reg == CH_O
                   && sh2_reg == CH_R;
        is_eoh   = (nt_reg == NAME_CW'(3)) && sh0_reg == CH_E && sh1_reg == CH_O
                   && sh2_reg == CH_H;
        bad_len  = (c_lp < LP_DIG) || (c_lp > LP_NTWS) || (c_acc > 17'hFFFF)
                   || ((c_lp == LP_NDIG || c_lp == LP_NTWS) && c_acc != '0);
        idx      = (c_fields == 8'hFF) ? 8'hFF : c_fields + 8'd1;
        up       = (in_byte >= 8'h61 && in_byte <= 8'h7A) ? in_byte - 8'h20 : in_byte;

        phase_next  = phase_reg;
        nc_next     = nc_reg;
        nt_next     = nt_reg;
        acc_next    = acc_reg;
        lp_next     = lp_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        bnone_next  = bnone_reg;
        begin_next  = begin_reg;
        topen_next  = topen_reg;
        fields_next = fields_reg;
        seq_next    = seq_reg;
        k_next      = k_reg;
        tail_next   = tail_reg;
        pkind_next  = pkind_reg;
        pchar_next  = pchar_reg;
        pfnum_next  = pfnum_reg;
        pss_next    = pss_reg;
        pse_next    = pse_reg;
        hlen_next   = hlen_reg;
        wr_en       = 1'b0;
        wr_data     = up;

        ov_next    = ov_reg && result_stall;
        okind_next = okind_reg;
        ochar_next = ochar_reg;
        olen_next  = olen_reg;
        ofnum_next = ofnum_reg;
        oss_next   = oss_reg;
        ose_next   = ose_reg;
        orun_next  = orun_reg;

        if (seq_reg == SQ_IDLE)
        begin
            if (byte_acc)
            begin
                phase_next  = c_ph;
                nc_next     = c_nc;
                nt_next     = c_nt;
                acc_next    = c_acc;
                lp_next     = c_lp;
                rem_next    = c_rem;
                pos_next    = c_pos;
                bnone_next  = c_bnone;
                begin_next  = c_begin;
                topen_next  = first_byte ? '0 : topen_reg;
                fields_next = c_fields;
                if (c_ph != PH_IDLE && c_ph != PH_DONE)
                begin
                    if (c_pos >= POS_W'(MESSAGE_MAX_BYTES))
                    begin
                        r_fail = 1'b1;
                    end
                    else
                    begin
                        case (c_ph)
                            PH_TEXT:
                            begin
                                if (in_byte == CH_LT)
                                begin
                                    topen_next = c_pos[15:0];
                                    nc_next    = '0;
                                    nt_next    = '0;
                                    acc_next   = '0;
                                    lp_next    = LP_BAD;
                                    phase_next = PH_NAME;
                                end
                            end
                            PH_NAME:
                            begin
                                if (in_byte == CH_GT)
                                begin
                                    do_close = 1'b1;
                                end
                                else if (in_byte == CH_COLON)
                                begin
                                    acc_next   = '0;
                                    lp_next    = LP_WS;
                                    phase_next = PH_LEN;
                                end
                                else if (is_ws(in_byte))
                                begin
                                    if (c_nc != '0 && c_nc < NAME_CW'(NAME_MAX))
                                    begin
                                        wr_en   = 1'b1;
                                        nc_next = c_nc + 1'b1;
                                    end
                                end
                                else if (c_nc >= NAME_CW'(NAME_MAX))
                                begin
                                    r_fail = 1'b1;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    nc_next = c_nc + 1'b1;
                                    nt_next = c_nc + 1'b1;
                                end
                            end
                            PH_LEN:
                            begin
                                if (in_byte == CH_GT)
                                begin
                                    do_close = 1'b1;
                                end
                                else if (in_byte == CH_COLON)
                                begin
                                    phase_next = PH_TYPE;
                                end
                                else
                                begin
                                    acc_next = ls_acc;
                                    lp_next  = ls_lp;
                                end
                            end
                            PH_TYPE:
                            begin
                                if (in_byte == CH_GT)
                                begin
                                    do_close = 1'b1;
                                end
                            end
                            default:
                            begin
                                r_one      = 1'b1;
                                pkind_next = K_VALUE;
                                pchar_next = in_byte;
                                pfnum_next = c_fields;
                                pss_next   = '0;
                                pse_next   = '0;
                                rem_next   = c_rem - 16'd1;
                                if (c_rem == 16'd1)
                                begin
                                    phase_next = PH_TEXT;
                                end
                            end
                        endcase

                        // A tag close can only follow a byte of the same tag, so
                        // the registered name state is the current one here.
                        if (do_close)
                        begin
                            if (is_eor)
                            begin
                                if (c_bnone)
                                begin
                                    r_fail = 1'b1;
                                end
                                else
                                begin
                                    r_one      = 1'b1;
                                    pkind_next = K_ACCEPT;
                                    pchar_next = '0;
                                    pfnum_next = '0;
                                    pss_next   = c_begin;
                                    pse_next   = c_pos[15:0];
                                    phase_next = PH_DONE;
                                end
                            end
                            else if (is_eoh)
                            begin
                                r_one       = 1'b1;
                                pkind_next  = K_DISCARD;
                                pchar_next  = '0;
                                pfnum_next  = '0;
                                pss_next    = '0;
                                pse_next    = '0;
                                bnone_next  = 1'b1;
                                fields_next = '0;
                                phase_next  = PH_TEXT;
                            end
                            else if (bad_len)
                            begin
                                r_fail = 1'b1;
                            end
                            else
                            begin
                                r_burst = 1'b1;
                                if (c_bnone)
                                begin
                                    fields_next = '0;
                                    bnone_next  = 1'b0;
                                    begin_next  = topen_reg;
                                end
                                else
                                begin
                                    fields_next = idx;
                                end
                                hlen_next  = c_acc[15:0];
                                rem_next   = c_acc[15:0];
                                phase_next = (c_acc != '0) ? PH_VALUE : PH_TEXT;
                            end
                        end
                    end

                    if (r_fail)
                    begin
                        phase_next = PH_DONE;
                        r_one      = 1'b1;
                        pkind_next = K_FAIL;
                        pchar_next = '0;
                        pfnum_next = '0;
                        pss_next   = '0;
                        pse_next   = '0;
                    end
                    else if (final_byte && phase_next != PH_DONE)
                    begin
                        r_tail     = 1'b1;
                        phase_next = PH_DONE;
                    end

                    if (c_pos < POS_W'(MESSAGE_MAX_BYTES))
                    begin
                        pos_next = c_pos + 1'b1;
                    end
                end

                tail_next = r_tail && (r_burst || r_one);
                if (r_burst)
                begin
                    k_next   = '0;
                    seq_next = (nt_reg != '0) ? SQ_NAME : SQ_HEAD;
                end
                else if (r_one)
                begin
                    seq_next = SQ_ONE;
                end
                else if (r_tail)
                begin
                    seq_next = SQ_FAIL;
                end
            end
        end
        else if (out_free)
        begin
            ov_next    = 1'b1;
            okind_next = K_FAIL;
            ochar_next = '0;
            olen_next  = '0;
            ofnum_next = '0;
            oss_next   = '0;
            ose_next   = '0;
            orun_next  = 1'b1;
            case (seq_reg)
                SQ_NAME:
                begin
                    okind_next = K_CHAR;
                    ochar_next = rd_data;
                    ofnum_next = fields_reg;
                    orun_next  = 1'b0;
                    k_next     = k_reg + 1'b1;
                    if (k_reg + 1'b1 == nt_reg)
                    begin
                        seq_next = SQ_HEAD;
                    end
                end
                SQ_HEAD:
                begin
                    okind_next = K_HEADER;
                    olen_next  = hlen_reg;
                    ofnum_next = fields_reg;
                    orun_next  = !tail_reg;
                    seq_next   = tail_reg ? SQ_FAIL : SQ_IDLE;
                end
                SQ_ONE:
                begin
                    okind_next = pkind_reg;
                    ochar_next = pchar_reg;
                    ofnum_next = pfnum_reg;
                    oss_next   = pss_reg;
                    ose_next   = pse_reg;
                    orun_next  = !tail_reg;
                    seq_next   = tail_reg ? SQ_FAIL : SQ_IDLE;
                end
                default:
                begin
                    seq_next = SQ_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            nc_reg     <= '0;
            nt_reg     <= '0;
            acc_reg    <= '0;
            lp_reg     <= LP_WS;
            rem_reg    <= '0;
            pos_reg    <= '0;
            bnone_reg  <= 1'b1;
            begin_reg  <= '0;
            topen_reg  <= '0;
            fields_reg <= '0;
            seq_reg    <= SQ_IDLE;
            k_reg      <= '0;
            tail_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            nc_reg     <= nc_next;
            nt_reg     <= nt_next;
            acc_reg    <= acc_next;
            lp_reg     <= lp_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            bnone_reg  <= bnone_next;
            begin_reg  <= begin_next;
            topen_reg  <= topen_next;
            fields_reg <= fields_next;
            seq_reg    <= seq_next;
            k_reg      <= k_next;
            tail_reg   <= tail_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers, including a copy of the first three name bytes.
    always_ff @(posedge clk)
    begin
        pkind_reg <= pkind_next;
        pchar_reg <= pchar_next;
        pfnum_reg <= pfnum_next;
        pss_reg   <= pss_next;
        pse_reg   <= pse_next;
        hlen_reg  <= hlen_next;
        okind_reg <= okind_next;
        ochar_reg <= ochar_next;
        olen_reg  <= olen_next;
        ofnum_reg <= ofnum_next;
        oss_reg   <= oss_next;
        ose_reg   <= ose_next;
        orun_reg  <= orun_next;
        if (wr_en && c_nc == NAME_CW'(0))
        begin
            sh0_reg <= wr_data;
        end
        if (wr_en && c_nc == NAME_CW'(1))
        begin
            sh1_reg <= wr_data;
        end
        if (wr_en && c_nc == NAME_CW'(2))
        begin
            sh2_reg <= wr_data;
        end
    end

    assign result_valid = ov_reg;
    assign kind         = okind_reg;
    assign char_value   = ochar_reg;
    assign field_length = olen_reg;
    assign field_number = ofnum_reg;
    assign span_start   = oss_reg;
    assign span_end     = ose_reg;
    assign run_end      = orun_reg;

`ifndef SYNTHESIS
    a_name_index: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SQ_NAME |-> k_reg < nt_reg)
        else $error("name burst index beyond trimmed name");

    a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> rem_reg != '0)
        else $error("value phase with nothing left");

    a_accept_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == K_ACCEPT |-> run_end)
        else $error("accept is not the last result of its byte");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        byte_acc && !first_byte && phase_reg == PH_IDLE |=> seq_reg == SQ_IDLE)
        else $error("byte outside a message produced results");
`endif

endmodule
